// File: src/haas_surround_stereo_widener_defines.svh
// Assertion macros for the stereo widener.
// Depends on nothing; included by files that carry assertions.
`ifndef HAAS_SURROUND_STEREO_WIDENER_DEFINES_SVH
`define HAAS_SURROUND_STEREO_WIDENER_DEFINES_SVH
// Same-cycle implication, checked outside reset
`define HSW_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, checked outside reset
`define HSW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// File: src/hsw_pkg.sv
// Package for the stereo widener: payload structs, register codes, constants.
// No dependencies.
`timescale 1ns / 1ps
package hsw_pkg;

    typedef struct packed {
        logic               mode;
        logic signed [31:0] in_left;
        logic signed [31:0] in_right;
    } t_in;

    typedef struct packed {
        logic signed [31:0] out_left;
        logic signed [31:0] out_right;
    } t_out;

    typedef enum logic [2:0] {
        REG_LOW_COEF     = 3'd0,
        REG_HIGH_COEF    = 3'd1,
        REG_BASS_COEF    = 3'd2,
        REG_TREBLE_COEF  = 3'd3,
        REG_DELAY_SELECT = 3'd4,
        REG_SIDE_ONLY    = 3'd5,
        REG_BALANCE      = 3'd6,
        REG_WET_MIX      = 3'd7
    } t_reg_idx;

    localparam logic [11:0] DELAY_LEN [5] = '{12'd454, 12'd727, 12'd909, 12'd1363, 12'd2727};
    localparam logic [2:0]  SEL_MAX       = 3'd4;
    // n/100 = (n * RECIP_100) >> 37 for every 32-bit n; >> 38 gives n/200
    localparam logic [31:0] RECIP_100     = 32'h51EB_851F;
    localparam logic [31:0] CROSS_GAIN    = 32'd35;
    localparam logic [6:0]  FULL_WET      = 7'd100;

endpackage

// File: src/haas_surround_stereo_widener.sv
// Haas stereo widener top level: sequencer, shared multiplier, one delay memory.
// Depends on hsw_pkg and haas_surround_stereo_widener_defines.svh.
//
// Usage: input items arrive on i_in_valid/o_in_ready with an hsw_pkg::t_in payload;
// results leave on o_out_valid/i_out_ready as hsw_pkg::t_out. A transfer on either
// side happens when valid and ready are both high. Registers are written through
// i_cfg_we/i_cfg_index/i_cfg_data; the user must write them only while the block
// is idle, which the block itself does not enforce. One item is worked at a time.
// A sample frame runs steps M0-M13, then B0-B4 when balance is nonzero, MID in
// side-only mode and W0-W8 when wet mix is not 100; the sequence is set by the
// single shared multiplier, which carries every fractional multiply and every
// division by 100 or 200 (reciprocal multiply). All five delay lines share one
// memory with one read and one write port; each frame reads five entries and
// writes five. A clear item sweeps the whole memory, one entry a cycle
// (MAX_DELAY * 23 / 8 entries, rounded per line), then gives a zero result.
// After reset the same sweep runs before the first item is taken; configuration
// writes are taken throughout.
// A finished result waits in the output register; while it is not taken the
// next item can still be accepted and worked, and the next result waits for it.
`timescale 1ns / 1ps
`include "haas_surround_stereo_widener_defines.svh"
module haas_surround_stereo_widener #(
    parameter int MAX_DELAY = 2727
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  hsw_pkg::t_in     i_in,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output hsw_pkg::t_out    o_out,
    input  logic             i_cfg_we,
    input  logic [2:0]       i_cfg_index,
    input  logic [30:0]      i_cfg_data
);

    // Line sizes and their places in the shared memory
    localparam int SZ0   = MAX_DELAY;
    localparam int SZ1   = MAX_DELAY / 8;
    localparam int SZ2   = MAX_DELAY / 4;
    localparam int SZ3   = MAX_DELAY;
    localparam int SZ4   = MAX_DELAY / 2;
    localparam int B1    = SZ0;
    localparam int B2    = B1 + SZ1;
    localparam int B3    = B2 + SZ2;
    localparam int B4    = B3 + SZ3;
    localparam int TOTAL = B4 + SZ4;
    localparam int AW    = $clog2(TOTAL);
    localparam logic [11:0] MAXD = 12'(MAX_DELAY);

    typedef enum logic [5:0] {
        S_IDLE, S_CLR, S_DONE,
        S_M0, S_M1, S_M2, S_M3, S_M4, S_M5, S_M6, S_M7,
        S_M8, S_M9, S_M10, S_M11, S_M12, S_M13,
        S_B0, S_B1, S_B2, S_B3, S_B4, S_MID,
        S_W0, S_W1, S_W2, S_W3, S_W4, S_W5, S_W6, S_W7, S_W8
    } t_state;

    t_state r_state;

    // Configuration
    logic [30:0] r_low, r_high, r_bass, r_treble;
    logic [2:0]  r_sel;
    logic        r_side;
    logic [6:0]  r_bal, r_wet;

    // Work registers
    logic [31:0] r_left, r_right, r_src, r_mid;
    logic [31:0] r_t0, r_t1, r_x, r_q, r_q1, r_acc;
    logic [31:0] r_old [5];
    logic [11:0] r_pos [5];
    logic        r_clr_item;
    logic [AW-1:0] r_cnt;
    logic signed [65:0] r_prod;
    logic        r_dneg, r_dsh;
    logic        r_ov;
    hsw_pkg::t_out r_out;

    // Memory
    logic [31:0] mem [TOTAL];
    logic [31:0] r_rd;
    logic [AW-1:0] raddr, waddr;
    logic [31:0] wdata;
    logic        we;

    // Combinational helpers
    logic signed [32:0] mul_a, mul_b;
    logic        c_dneg, c_dsh;
    logic [31:0] fm, lo32, q_mag, q;
    logic [11:0] d_raw, d_len;
    logic [11:0] len [5];
    logic [11:0] peff [5];
    logic [11:0] pnext [5];
    logic [AW-1:0] base [5];
    logic [2:0]  wline;
    logic [31:0] dry;

    function automatic logic [31:0] div2(input logic [31:0] v);
        logic [31:0] s;
        s = v + {31'd0, v[31]};
        return {s[31], s[31:1]};
    endfunction

    function automatic logic [31:0] mag(input logic [31:0] v);
        return v[31] ? (32'd0 - v) : v;
    endfunction

    // Delay length and line lengths
    always_comb begin
        d_raw = hsw_pkg::DELAY_LEN[(r_sel > hsw_pkg::SEL_MAX) ? hsw_pkg::SEL_MAX : r_sel];
        d_len = (d_raw > MAXD) ? MAXD : d_raw;
        len[0] = d_len;
        len[1] = d_len >> 3;
        len[2] = d_len >> 2;
        len[3] = d_len;
        len[4] = d_len >> 1;
        base[0] = '0;
        base[1] = AW'(B1);
        base[2] = AW'(B2);
        base[3] = AW'(B3);
        base[4] = AW'(B4);
        for (int k = 0; k < 5; k++) begin
            peff[k]  = (r_pos[k] >= len[k]) ? 12'd0 : r_pos[k];
            pnext[k] = ((peff[k] + 12'd1) >= len[k]) ? 12'd0 : (peff[k] + 12'd1);
        end
    end

    // Product views
    always_comb begin
        fm    = r_prod[62:31];
        lo32  = r_prod[31:0];
        q_mag = r_dsh ? {6'd0, r_prod[63:38]} : {5'd0, r_prod[63:37]};
        q     = r_dneg ? (32'd0 - q_mag) : q_mag;
        dry   = 32'd100 - {25'd0, r_wet};
    end

    // Multiplier operands, memory port control
    always_comb begin
        mul_a  = '0;
        mul_b  = '0;
        c_dneg = 1'b0;
        c_dsh  = 1'b0;
        raddr  = '0;
        we     = 1'b0;
        wline  = 3'd0;
        wdata  = '0;
        case (r_state)
            S_M0:  begin mul_a = {r_src[31], r_src}; mul_b = {2'b0, r_low}; end
            S_M1:  begin mul_a = {r_src[31], r_src}; mul_b = {2'b0, r_high}; end
            S_M3:  begin
                mul_a = {1'b0, mag(r_t1)}; mul_b = {1'b0, hsw_pkg::RECIP_100};
                c_dneg = r_t1[31];
            end
            S_M4:  begin mul_a = {q[31], q}; mul_b = {1'b0, hsw_pkg::CROSS_GAIN}; end
            S_M5:  begin
                mul_a = {r_right[31], r_right}; mul_b = {2'b0, r_low};
                we = 1'b1; wline = 3'd0; wdata = 32'd0 - lo32;
            end
            S_M6:  begin we = 1'b1; wline = 3'd1; wdata = r_right - fm; end
            S_M7:  begin mul_a = {r_t1[31], r_t1}; mul_b = {2'b0, r_bass}; end
            S_M8:  begin mul_a = {r_right[31], r_right}; mul_b = {2'b0, r_bass}; end
            S_M9:  begin
                mul_a = {r_right[31], r_right}; mul_b = {2'b0, r_high};
                we = 1'b1; wline = 3'd2; wdata = r_right - fm;
            end
            S_M10: begin we = 1'b1; wline = 3'd3; wdata = fm; end
            S_M11: begin mul_a = {r_t1[31], r_t1}; mul_b = {2'b0, r_treble}; end
            S_M12: begin mul_a = {r_right[31], r_right}; mul_b = {2'b0, r_treble}; end
            S_M13: begin we = 1'b1; wline = 3'd4; wdata = fm; end
            S_B0:  begin
                mul_a = {1'b0, mag(r_t0)}; mul_b = {1'b0, hsw_pkg::RECIP_100};
                c_dneg = r_t0[31]; c_dsh = 1'b1;
            end
            S_B1:  begin
                mul_a = {1'b0, mag(r_t1)}; mul_b = {1'b0, hsw_pkg::RECIP_100};
                c_dneg = r_t1[31]; c_dsh = 1'b1;
            end
            S_B2:  begin mul_a = {r_q[31], r_q}; mul_b = {26'd0, r_bal}; end
            S_B3:  begin mul_a = {r_q1[31], r_q1}; mul_b = {26'd0, r_bal}; end
            S_W0:  begin
                mul_a = {1'b0, mag(r_left)}; mul_b = {1'b0, hsw_pkg::RECIP_100};
                c_dneg = r_left[31];
            end
            S_W1:  begin
                mul_a = {1'b0, mag(r_t0)}; mul_b = {1'b0, hsw_pkg::RECIP_100};
                c_dneg = r_t0[31];
            end
            S_W2, S_W6: begin mul_a = {r_q[31], r_q}; mul_b = {dry[31], dry}; end
            S_W3, S_W7: begin mul_a = {r_q1[31], r_q1}; mul_b = {26'd0, r_wet}; end
            S_W4:  begin
                mul_a = {1'b0, mag(r_right)}; mul_b = {1'b0, hsw_pkg::RECIP_100};
                c_dneg = r_right[31];
            end
            S_W5:  begin
                mul_a = {1'b0, mag(r_t1)}; mul_b = {1'b0, hsw_pkg::RECIP_100};
                c_dneg = r_t1[31];
            end
            S_CLR: begin we = 1'b1; wdata = '0; end
            default: ;
        endcase
        // Line k is read in step M0+k
        case (r_state)
            S_M0: raddr = base[0] + AW'(peff[0]);
            S_M1: raddr = base[1] + AW'(peff[1]);
            S_M2: raddr = base[2] + AW'(peff[2]);
            S_M3: raddr = base[3] + AW'(peff[3]);
            S_M4: raddr = base[4] + AW'(peff[4]);
            default: raddr = '0;
        endcase
        waddr = (r_state == S_CLR) ? r_cnt : (base[wline] + AW'(peff[wline]));
    end

    // Delay memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        r_rd <= mem[raddr];
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ov;
    assign o_out       = r_out;

    // Sequencer, datapath registers and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLR;
            r_cnt      <= '0;
            r_clr_item <= 1'b0;
            r_ov       <= 1'b0;
            r_low      <= '0;
            r_high     <= '0;
            r_bass     <= '0;
            r_treble   <= '0;
            r_sel      <= 3'd4;
            r_side     <= 1'b0;
            r_bal      <= '0;
            r_wet      <= hsw_pkg::FULL_WET;
            for (int k = 0; k < 5; k++) begin
                r_pos[k] <= '0;
            end
        end else begin
            r_prod <= mul_a * mul_b;
            r_dneg <= c_dneg;
            r_dsh  <= c_dsh;

            // Register writes
            if (i_cfg_we) begin
                case (i_cfg_index)
                    hsw_pkg::REG_LOW_COEF:     r_low    <= i_cfg_data;
                    hsw_pkg::REG_HIGH_COEF:    r_high   <= i_cfg_data;
                    hsw_pkg::REG_BASS_COEF:    r_bass   <= i_cfg_data;
                    hsw_pkg::REG_TREBLE_COEF:  r_treble <= i_cfg_data;
                    hsw_pkg::REG_DELAY_SELECT: r_sel    <= i_cfg_data[2:0];
                    hsw_pkg::REG_SIDE_ONLY:    r_side   <= i_cfg_data[0];
                    hsw_pkg::REG_BALANCE:      r_bal    <= i_cfg_data[6:0];
                    hsw_pkg::REG_WET_MIX:      r_wet    <= i_cfg_data[6:0];
                    default: ;
                endcase
            end

            // Drop the result once taken, unless a new one loads in its place
            if (r_ov && i_out_ready && r_state != S_DONE) begin
                r_ov <= 1'b0;
            end

            // Advance position of the line just written
            if (we && r_state != S_CLR) begin
                r_pos[wline] <= pnext[wline];
            end

            // Capture old entries from the registered read data in the step after their read
            case (r_state)
                S_M1: r_old[0] <= r_rd;
                S_M2: r_old[1] <= r_rd;
                S_M3: r_old[2] <= r_rd;
                S_M4: r_old[3] <= r_rd;
                S_M5: r_old[4] <= r_rd;
                default: ;
            endcase

            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_left  <= i_in.in_left;
                        r_right <= i_in.in_right;
                        r_src   <= r_side ? (i_in.in_right - i_in.in_left) : i_in.in_right;
                        r_mid   <= div2(i_in.in_left) + div2(i_in.in_right);
                        if (i_in.mode) begin
                            r_clr_item <= 1'b1;
                            r_cnt      <= '0;
                            r_state    <= S_CLR;
                        end else begin
                            r_state <= S_M0;
                        end
                    end
                end
                S_CLR: begin
                    for (int k = 0; k < 5; k++) begin
                        r_pos[k] <= '0;
                    end
                    r_cnt <= r_cnt + AW'(1);
                    if (r_cnt == AW'(TOTAL - 1)) begin
                        r_t0    <= '0;
                        r_t1    <= '0;
                        r_state <= r_clr_item ? S_DONE : S_IDLE;
                    end
                end
                S_M0: r_state <= S_M1;
                S_M1: begin
                    r_x     <= fm;
                    r_state <= S_M2;
                end
                S_M2: begin
                    if (r_side) begin
                        r_t0 <= div2(r_left - r_right);
                        r_t1 <= div2(r_x) - div2(fm);
                    end else begin
                        r_t0 <= r_left;
                        r_t1 <= r_x - fm;
                    end
                    r_state <= S_M3;
                end
                S_M3: r_state <= S_M4;
                S_M4: begin
                    r_q     <= q;
                    r_state <= S_M5;
                end
                S_M5: begin
                    r_t0    <= r_t0 + r_old[0];
                    r_state <= S_M6;
                end
                S_M6: begin
                    r_t1    <= r_t1 + r_old[1];
                    r_state <= S_M7;
                end
                S_M7: r_state <= S_M8;
                S_M8: begin
                    r_t1    <= fm;
                    r_state <= S_M9;
                end
                S_M9: begin
                    r_t1    <= r_t1 + r_old[2];
                    r_state <= S_M10;
                end
                S_M10: begin
                    r_t1    <= r_t1 + r_old[3];
                    r_state <= S_M11;
                end
                S_M11: r_state <= S_M12;
                S_M12: begin
                    r_t1    <= r_t1 - fm;
                    r_state <= S_M13;
                end
                S_M13: begin
                    r_t1 <= r_t1 + r_old[4];
                    if (r_bal != '0) begin
                        r_state <= S_B0;
                    end else if (r_side) begin
                        r_state <= S_MID;
                    end else if (r_wet != hsw_pkg::FULL_WET) begin
                        r_state <= S_W0;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_B0: r_state <= S_B1;
                S_B1: begin
                    r_q     <= q;
                    r_state <= S_B2;
                end
                S_B2: begin
                    r_q1    <= q;
                    r_state <= S_B3;
                end
                S_B3: begin
                    r_t0    <= r_side ? (r_t0 + lo32) : (r_t0 - lo32);
                    r_state <= S_B4;
                end
                S_B4: begin
                    r_t1 <= r_side ? (r_t1 - lo32) : (r_t1 + lo32);
                    if (r_side) begin
                        r_state <= S_MID;
                    end else if (r_wet != hsw_pkg::FULL_WET) begin
                        r_state <= S_W0;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_MID: begin
                    r_t0    <= r_t0 + r_mid;
                    r_t1    <= r_t1 + r_mid;
                    r_state <= (r_wet != hsw_pkg::FULL_WET) ? S_W0 : S_DONE;
                end
                S_W0: r_state <= S_W1;
                S_W1: begin
                    r_q     <= q;
                    r_state <= S_W2;
                end
                S_W2: begin
                    r_q1    <= q;
                    r_state <= S_W3;
                end
                S_W3: begin
                    r_acc   <= lo32;
                    r_state <= S_W4;
                end
                S_W4: begin
                    r_t0    <= r_acc + lo32;
                    r_state <= S_W5;
                end
                S_W5: begin
                    r_q     <= q;
                    r_state <= S_W6;
                end
                S_W6: begin
                    r_q1    <= q;
                    r_state <= S_W7;
                end
                S_W7: begin
                    r_acc   <= lo32;
                    r_state <= S_W8;
                end
                S_W8: begin
                    r_t1    <= r_acc + lo32;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    // Hold until the output register is free
                    if (!r_ov || i_out_ready) begin
                        r_out.out_left  <= r_t0;
                        r_out.out_right <= r_t1;
                        r_ov            <= 1'b1;
                        r_clr_item      <= 1'b0;
                        r_state         <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `HSW_ASSERT_NOW(a_clr_writes_zero, r_state == S_CLR, we && wdata == 32'd0, "clear sweep must write zero")
    `HSW_ASSERT_NEXT(a_clr_item_sweeps, i_in_valid && o_in_ready && i_in.mode, r_state == S_CLR, "clear item must start the sweep")
    `HSW_ASSERT_NEXT(a_done_loads, r_state == S_DONE && (!r_ov || i_out_ready), o_out_valid && r_state == S_IDLE, "finished result must load the output register")
    `HSW_ASSERT_NOW(a_no_write_while_read, r_state == S_M0 || r_state == S_M1 || r_state == S_M2 || r_state == S_M3 || r_state == S_M4, !we, "line write overlaps the read phase")

endmodule
